@@ rtl/serial_frame_encoder_xor_top_assert.svh @@
// ============================================================================
// Assertion macros for the serial frame encoder
// Concurrent checks on the clk domain, removed when SYNTHESIS is defined.
// ============================================================================
`ifndef SERIAL_FRAME_ENCODER_XOR_TOP_ASSERT_SVH
`define SERIAL_FRAME_ENCODER_XOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SFE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfe assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfe assertion failed");

`else

`define SFE_ASSERT_NOW(label, ante, cons)
`define SFE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/sfe_pkg.sv @@
// ============================================================================
// sfe_pkg
// Types and constants shared by the serial frame encoder modules.
// ============================================================================
`timescale 1ns / 1ps

package sfe_pkg;

    // Start-of-frame byte that opens every frame.
    localparam logic [7:0] SOF_BYTE = 8'hFE;

    // Largest number of bytes one input item can produce.
    localparam int MAX_BURST = 6;
    localparam int CNT_W     = 3;

    localparam logic [CNT_W-1:0] CNT_HEADER      = 3'd5;
    localparam logic [CNT_W-1:0] CNT_HEADER_CKS  = 3'd6;
    localparam logic [CNT_W-1:0] CNT_PAYLOAD     = 3'd1;
    localparam logic [CNT_W-1:0] CNT_PAYLOAD_CKS = 3'd2;
    localparam logic [CNT_W-1:0] CNT_NONE        = 3'd0;

    typedef enum logic
    {
        ACT_START   = 1'b0,
        ACT_PAYLOAD = 1'b1
    } action_t;

    typedef struct packed
    {
        logic        action;
        logic [15:0] msg_function;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed
    {
        logic [7:0] tx_byte;
        logic       frame_end;
    } result_t;

    // The bytes one item produces, in transmit order from index 0.
    typedef struct packed
    {
        logic [MAX_BURST-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      has_end;
    } burst_t;

    // Status of the output serializer toward the top level.
    typedef struct packed
    {
        logic can_load;
        logic last;
    } burst_sts_t;

endpackage

@@ rtl/sfe_frame_logic.sv @@
// ============================================================================
// sfe_frame_logic
// Framing state and the combinational expansion of one item into a burst.
// ============================================================================
`timescale 1ns / 1ps

module sfe_frame_logic
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  sfe_pkg::item_t  item,
    output sfe_pkg::burst_t burst
);

    import sfe_pkg::*;

    logic        in_message_reg;
    logic        in_message_next;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic [7:0]  checksum_reg;
    logic [7:0]  checksum_next;

    logic [7:0]  hdr_cks;
    logic [7:0]  pay_cks;
    logic        pay_last;

    assign hdr_cks  = SOF_BYTE ^ item.msg_function[15:8] ^ item.msg_function[7:0]
                    ^ item.payload_length[15:8] ^ item.payload_length[7:0];
    assign pay_cks  = checksum_reg ^ item.data_byte;
    assign pay_last = (remaining_reg == 16'd1);

    always_comb
    begin
        burst           = '0;
        in_message_next = in_message_reg;
        remaining_next  = remaining_reg;
        checksum_next   = checksum_reg;
        if (item.action == ACT_START)
        begin
            burst.bytes[0] = SOF_BYTE;
            burst.bytes[1] = item.msg_function[15:8];
            burst.bytes[2] = item.msg_function[7:0];
            burst.bytes[3] = item.payload_length[15:8];
            burst.bytes[4] = item.payload_length[7:0];
            burst.bytes[5] = hdr_cks;
            if (item.payload_length == 16'd0)
            begin
                burst.count     = CNT_HEADER_CKS;
                burst.has_end   = 1'b1;
                in_message_next = 1'b0;
                remaining_next  = 16'd0;
                checksum_next   = 8'd0;
            end
            else
            begin
                burst.count     = CNT_HEADER;
                in_message_next = 1'b1;
                remaining_next  = item.payload_length;
                checksum_next   = hdr_cks;
            end
        end
        else if (in_message_reg)
        begin
            burst.bytes[0] = item.data_byte;
            burst.bytes[1] = pay_cks;
            if (pay_last)
            begin
                burst.count     = CNT_PAYLOAD_CKS;
                burst.has_end   = 1'b1;
                in_message_next = 1'b0;
                remaining_next  = 16'd0;
                checksum_next   = 8'd0;
            end
            else
            begin
                burst.count    = CNT_PAYLOAD;
                remaining_next = remaining_reg - 16'd1;
                checksum_next  = pay_cks;
            end
        end
        else
        begin
            // Payload with no open frame is dropped.
            burst.count = CNT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
            remaining_reg  <= 16'd0;
            checksum_reg   <= 8'd0;
        end
        else if (fire)
        begin
            in_message_reg <= in_message_next;
            remaining_reg  <= remaining_next;
            checksum_reg   <= checksum_next;
        end
    end

endmodule

@@ rtl/sfe_burst_out.sv @@
// ============================================================================
// sfe_burst_out
// Burst register that hands out one frame byte per transfer.
// ============================================================================
`timescale 1ns / 1ps

module sfe_burst_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  sfe_pkg::burst_t     burst,
    output logic                valid,
    input  logic                stall,
    output sfe_pkg::result_t    result,
    output sfe_pkg::burst_sts_t sts
);

    import sfe_pkg::*;

    logic [MAX_BURST-1:0][7:0] bytes_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [CNT_W-1:0]          idx_reg;
    logic [CNT_W-1:0]          idx_next;
    logic                      end_reg;
    logic                      end_next;

    assign valid        = (count_reg != CNT_NONE);
    assign sts.last     = valid && (idx_reg == (count_reg - 3'd1));
    assign sts.can_load = !valid || (sts.last && !stall);

    assign result.tx_byte   = bytes_reg[idx_reg];
    assign result.frame_end = end_reg && sts.last;

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        if (load)
        begin
            count_next = burst.count;
            idx_next   = '0;
            end_next   = burst.has_end;
        end
        else if (valid && !stall)
        begin
            if (sts.last)
            begin
                count_next = CNT_NONE;
                idx_next   = '0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_NONE;
            idx_reg   <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= burst.bytes;
        end
    end

endmodule

@@ rtl/serial_frame_encoder_xor_top.sv @@
// An item waits in the input register, then its bytes in the burst register.
// Throughput: one item transfer per cycle while each produces at most one byte
// and the output is not stalled. Through the single byte-wide output port a
// start item sends five or six bytes, a closing payload two, a dropped item none.
// Reset: rst_n is asynchronous and active low; it empties both registers and
// closes any open frame.
// ============================================================================
// serial_frame_encoder_xor_top
// Serial framer: start byte, function code, length, payload, XOR checksum.
// ============================================================================
`timescale 1ns / 1ps
`include "serial_frame_encoder_xor_top_assert.svh"

module serial_frame_encoder_xor_top
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  sfe_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output sfe_pkg::result_t result
);

    import sfe_pkg::*;

    // The design has two register stages. The input register takes one item
    // per transfer. When the burst register can take new work, the item passes
    // through the framing logic, which updates the frame state and writes all
    // bytes the item produces into the burst register in one step. The burst
    // register then offers those bytes one per result transfer, so an item
    // can be taken in while earlier bytes still wait downstream.

    item_t      item_reg;
    logic       item_valid_reg;
    logic       item_valid_next;
    logic       accept;
    logic       move;
    burst_t     burst;
    burst_sts_t sts;

    assign accept     = item_valid && !item_stall;
    assign move       = item_valid_reg && sts.can_load;
    assign item_stall = item_valid_reg && !sts.can_load;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (move)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // Item payload carries no reset; it is qualified by item_valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    // The frame state advances exactly when an item leaves the input register,
    // so state updates stay in item order.
    sfe_frame_logic u_frame
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (move),
        .item  (item_reg),
        .burst (burst)
    );

    sfe_burst_out u_out
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (move),
        .burst  (burst),
        .valid  (result_valid),
        .stall  (result_stall),
        .result (result),
        .sts    (sts)
    );

    // The input side only stalls while an item is held.
    `SFE_ASSERT_NOW(a_stall_needs_item, item_stall, item_valid_reg)
    // A checksum byte is always the last byte of its burst.
    `SFE_ASSERT_NOW(a_end_is_last, result_valid && result.frame_end, sts.last)
    // An item that moves on with nothing new behind it leaves the register empty.
    `SFE_ASSERT_NEXT(a_move_empties, move && !accept, !item_valid_reg)

endmodule

@@ test/serial_frame_encoder_xor_top_tb.sv @@
// ============================================================================
// serial_frame_encoder_xor_top_tb
// Self-checking bench for the serial framer. Start and payload items go in
// with random gaps, and a local frame model predicts every transmitted byte.
// Each byte that comes out is compared, field by field, against the oldest
// prediction, while the output side stalls at random.
// ============================================================================
`timescale 1ns / 1ps

module serial_frame_encoder_xor_top_tb;

    import sfe_pkg::*;

    // Cycles with no transfer on either side before the run is declared hung.
    localparam int IDLE_LIMIT = 1000;

    // Cycles allowed after the last expected byte for stray output to show up.
    localparam int DRAIN_CYCLES = 20;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Items still waiting to be presented, and bytes the frame model expects.
    item_t   pending_items[$];
    result_t expected_bytes[$];

    // Frame model state: open frame flag, payload bytes left, running XOR.
    logic        frame_open = 1'b0;
    logic [15:0] bytes_left = '0;
    logic [7:0]  frame_xor  = '0;

    int mismatches   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int gap_left     = 0;
    int hold_left    = 0;
    int idle_cycles  = 0;

    // Scratch values that the driver and the monitor work out within one edge.
    logic    next_valid;
    item_t   next_item;
    result_t want;

    serial_frame_encoder_xor_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Frame model
    // ------------------------------------------------------------------------

    // Queues one byte for transmission. Every byte except the closing checksum
    // is folded into the running XOR.
    function automatic void queue_frame_byte(logic [7:0] value, logic last);
        result_t r;
        r.tx_byte   = value;
        r.frame_end = last;
        expected_bytes.push_back(r);
        if (!last)
        begin
            frame_xor = frame_xor ^ value;
        end
    endfunction

    // Sends the checksum and leaves the model with no frame open.
    function automatic void close_frame();
        queue_frame_byte(frame_xor, 1'b1);
        frame_open = 1'b0;
        bytes_left = '0;
        frame_xor  = '0;
    endfunction

    // Works out the bytes that one accepted item puts on the output.
    function automatic void encode_frame_item(item_t it);
        if (it.action == ACT_START)
        begin
            // A start always opens a fresh frame, dropping any open one
            // without its checksum.
            frame_xor = '0;
            queue_frame_byte(SOF_BYTE, 1'b0);
            queue_frame_byte(it.msg_function[15:8], 1'b0);
            queue_frame_byte(it.msg_function[7:0], 1'b0);
            queue_frame_byte(it.payload_length[15:8], 1'b0);
            queue_frame_byte(it.payload_length[7:0], 1'b0);
            if (it.payload_length == 16'd0)
            begin
                close_frame();
            end
            else
            begin
                frame_open = 1'b1;
                bytes_left = it.payload_length;
            end
        end
        else if (frame_open)
        begin
            queue_frame_byte(it.data_byte, 1'b0);
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0)
            begin
                close_frame();
            end
        end
        // A payload byte with no open frame is dropped without output.
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers. The fields that an item does not use get random
    // values, so that the block is seen to ignore them.
    // ------------------------------------------------------------------------

    function automatic void add_start(logic [15:0] code, logic [15:0] len);
        item_t it;
        it.action         = ACT_START;
        it.msg_function   = code;
        it.payload_length = len;
        it.data_byte      = 8'($urandom);
        pending_items.push_back(it);
    endfunction

    function automatic void add_payload(logic [7:0] value);
        item_t it;
        it.action         = ACT_PAYLOAD;
        it.msg_function   = 16'($urandom);
        it.payload_length = 16'($urandom);
        it.data_byte      = value;
        pending_items.push_back(it);
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp_val);
        $display("MISMATCH %s: got %02h, expected %02h, at %0t ns",
                 what, got, exp_val, $time);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Driver. It presents the pending items one by one. After each transfer it
    // may hold back the next item for a random gap, except during stretches of
    // back-to-back traffic. Valid and payload are worked out in blocking scratch
    // variables, so each gets exactly one nonblocking assignment per edge and a
    // held item never drops for a cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
            gap_left    = 0;
        end
        else
        begin
            next_valid = item_valid;
            next_item  = item;
            if (item_valid && !item_stall)
            begin
                // The transfer happens at this edge, so the model is advanced
                // right here, well before the bytes of this item can appear.
                encode_frame_item(item);
                items_sent++;
                next_valid = 1'b0;
                gap_left   = (items_sent % 64 < 16) ? 0 : $urandom_range(0, 9);
            end
            if (!next_valid && pending_items.size() != 0)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else
                begin
                    next_item  = pending_items.pop_front();
                    next_valid = 1'b1;
                end
            end
            item_valid <= next_valid;
            item       <= next_item;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each transferred byte is checked against the oldest expected
    // byte. After each transfer the stall may be raised for a random hold,
    // except during stretches with no stalls. The stall runs whether or
    // not output is waiting, so it falls on every phase of a frame.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left     = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("byte with nothing expected", result.tx_byte, 8'h00);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (result.tx_byte !== want.tx_byte)
                    begin
                        report_mismatch("tx_byte", result.tx_byte, want.tx_byte);
                    end
                    if (result.frame_end !== want.frame_end)
                    begin
                        report_mismatch("frame_end", 8'(result.frame_end),
                                        8'(want.frame_end));
                    end
                end
                results_seen++;
                hold_left = (results_seen % 80 < 20) ? 0 : $urandom_range(0, 9);
            end
            else if (hold_left > 0)
            begin
                hold_left--;
            end
            result_stall <= (hold_left > 0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. It counts the cycles in which neither side transfers and ends
    // the run if the block stops making progress.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build the stimulus, release reset, let the driver work through
    // the items, wait for the output to drain, then give the verdict.
    // ------------------------------------------------------------------------
    initial
    begin : run_sequence
        int          frame_items;
        int          pick;
        int          n_bytes;
        logic [15:0] len;

        // Directed frames. A payload byte right after reset must be dropped.
        add_payload(8'hA5);
        // Zero length, all ones and all zeros in the function code: the
        // checksum follows the header at once.
        add_start(16'hFFFF, 16'h0000);
        add_start(16'h0000, 16'h0000);
        // Single payload byte of zero closes the frame.
        add_start(16'h1234, 16'h0001);
        add_payload(8'h00);
        // Outside a frame again, so this byte is dropped as well.
        add_payload(8'hFF);
        // Short frame with extreme payload values.
        add_start(16'hABCD, 16'h0003);
        add_payload(8'hFF);
        add_payload(8'h00);
        add_payload(8'h5A);
        // Longest length, cut off by a new start that then completes.
        add_start(16'h8001, 16'hFFFF);
        add_payload(8'h01);
        add_payload(8'h80);
        add_start(16'h7FFE, 16'h0002);
        add_payload(8'hC3);
        add_payload(8'h3C);
        // Length with a zero low byte, cut off by a zero-length start.
        add_start(16'h00FF, 16'h0100);
        add_payload(8'h11);
        add_start(16'hFF00, 16'h0000);

        // Random frames. Most of them are short and complete. Some have zero
        // length, and some are long and are cut off by the next start, which
        // also exercises the upper length bits. One short frame in ten is cut
        // off early. Stray payload bytes are mixed in as noise and are not counted;
        // outside a frame the block drops them, and an open frame takes them in.
        frame_items = 0;
        while (frame_items < 200)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                add_payload(8'($urandom));
            end
            else
            begin
                if (pick < 18)
                begin
                    len = 16'd0;
                end
                else if (pick < 28)
                begin
                    len = 16'($urandom_range(9, 65535));
                end
                else
                begin
                    len = 16'($urandom_range(1, 8));
                end
                n_bytes = len;
                if (len > 16'd8)
                begin
                    n_bytes = $urandom_range(0, 4);
                end
                else if (len != 16'd0 && $urandom_range(0, 9) == 0)
                begin
                    n_bytes = $urandom_range(0, len - 1);
                end
                add_start(16'($urandom), len);
                repeat (n_bytes) add_payload(8'($urandom));
                frame_items += 1 + n_bytes;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Polling on the falling edge keeps clear of the driver's updates at
        // the rising edge.
        while (pending_items.size() != 0 || item_valid)
        begin
            @(negedge clk);
        end
        while (expected_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
